FILE: hw/rtl/laps_pkg.sv
// shared types and constants for the led alert pattern sequencer
// no dependencies; used by laps_ctrl, laps_datapath and the top level
package laps_pkg;

    // input opcodes
    localparam logic [1:0] OP_COMMAND  = 2'd0;
    localparam logic [1:0] OP_ROLLOVER = 2'd1;
    localparam logic [1:0] OP_FRAME    = 2'd2;

    // button codes
    localparam logic [7:0] CMD_OFF    = 8'hA6;
    localparam logic [7:0] CMD_WAVE   = 8'hB5;
    localparam logic [7:0] CMD_PULSE  = 8'hC0;
    localparam logic [7:0] CMD_REDYEL = 8'hD2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ORDER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd1;

    localparam logic       COLOR_ORDER_RST   = 1'b1;
    localparam logic [7:0] TIMEOUT_RST       = 8'd27;

    // animation constants
    localparam logic [7:0] PULSE_STEP     = 8'd5;
    localparam logic [7:0] PULSE_TOP      = 8'd250;
    localparam logic [7:0] PULSE_BOTTOM   = 8'h0F;
    localparam logic [7:0] PULSE_RST      = 8'h0F;
    localparam logic [7:0] PULSE_START    = 8'hFF;
    localparam logic [7:0] YELLOW_GREEN   = 8'h7F;
    localparam logic [3:0] WAVE_LAST      = 4'd14;

    localparam logic [8:0] HOLD_OFF       = 9'd0;
    localparam logic [8:0] HOLD_ANIM      = 9'd20;
    localparam logic [8:0] HOLD_REDYEL    = 9'd500;

    localparam int unsigned LED_W = 6;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_WAVE   = 2'd1,
        MODE_PULSE  = 2'd2,
        MODE_REDYEL = 2'd3
    } t_mode;

    // controller to datapath
    typedef struct packed {
        logic do_command;
        logic do_rollover;
        logic frame_start;
        logic load_led;
        logic frame_end;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_led;
    } t_dp_status;

    // blue level of the wave for one phase
    function automatic logic [7:0] wave_blue(input logic [3:0] phase);
        logic [7:0] b;
        case (phase)
            4'd3:    b = 8'h0F;
            4'd4:    b = 8'h1F;
            4'd5:    b = 8'h3F;
            4'd6:    b = 8'h7F;
            4'd7:    b = 8'hFF;
            4'd8:    b = 8'h7F;
            4'd9:    b = 8'h3F;
            4'd10:   b = 8'h1F;
            4'd11:   b = 8'h0F;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] wave_next(input logic [3:0] phase);
        return (phase >= WAVE_LAST) ? 4'd0 : phase + 4'd1;
    endfunction

endpackage

FILE: hw/rtl/laps_ctrl.sv
// controller state machine: input handshake, frame sequencing, output valid
// depends on laps_pkg
module laps_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_opcode,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output laps_pkg::t_dp_cmd     o_cmd,
    input  laps_pkg::t_dp_status  i_status
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, take, can_load;

    assign o_in_stall  = (r_state == ST_EMIT);
    assign o_out_valid = r_out_valid;

    always_comb begin
        accept   = i_in_valid && (r_state == ST_IDLE);
        take     = r_out_valid && !i_out_stall;
        can_load = (r_state == ST_EMIT) && (!r_out_valid || take);

        o_cmd.do_command  = accept && (i_opcode == laps_pkg::OP_COMMAND);
        o_cmd.do_rollover = accept && (i_opcode == laps_pkg::OP_ROLLOVER);
        o_cmd.frame_start = accept && (i_opcode == laps_pkg::OP_FRAME);
        o_cmd.load_led    = can_load;
        o_cmd.frame_end   = can_load && i_status.last_led;

        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.frame_start) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (o_cmd.frame_end) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        if (can_load) n_out_valid = 1'b1;
        else if (take) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/laps_datapath.sv
// datapath: mode and animation state, config registers, per-led colour
// and the output word register; depends on laps_pkg
module laps_datapath #(
    parameter int unsigned LED_COUNT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  laps_pkg::t_dp_cmd             i_cmd,
    output laps_pkg::t_dp_status          o_status,
    input  logic [7:0]                    i_command_byte,
    input  logic                          i_cfg_write,
    input  logic [laps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    output logic [laps_pkg::LED_W-1:0]    o_led_index,
    output logic [7:0]                    o_first_byte,
    output logic [7:0]                    o_second_byte,
    output logic [7:0]                    o_third_byte,
    output logic                          o_last,
    output logic [8:0]                    o_hold_ms
);

    localparam logic [laps_pkg::LED_W-1:0] LastLed = laps_pkg::LED_W'(LED_COUNT - 1);

    laps_pkg::t_mode r_mode, n_mode;
    logic [7:0] r_count, n_count;
    logic [7:0] r_level, n_level;
    logic       r_rising, n_rising;
    logic [3:0] r_wave, n_wave;
    logic       r_red_even, n_red_even;
    logic       r_color_order;
    logic [7:0] r_timeout;
    logic [laps_pkg::LED_W-1:0] r_led;
    logic [3:0] r_phase;

    logic [7:0] red, green, blue, count_inc, level_step;
    logic [8:0] hold;

    assign o_status.last_led = (r_led == LastLed);

    // colour of the led at r_led
    always_comb begin
        red   = 8'h00;
        green = 8'h00;
        blue  = 8'h00;
        hold  = laps_pkg::HOLD_ANIM;
        case (r_mode)
            laps_pkg::MODE_OFF:   hold = laps_pkg::HOLD_OFF;
            laps_pkg::MODE_WAVE:  blue = laps_pkg::wave_blue(r_phase);
            laps_pkg::MODE_PULSE: red  = r_level;
            laps_pkg::MODE_REDYEL: begin
                hold  = laps_pkg::HOLD_REDYEL;
                red   = 8'hFF;
                green = (!r_led[0] == r_red_even) ? 8'h00 : laps_pkg::YELLOW_GREEN;
            end
            default: hold = laps_pkg::HOLD_OFF;
        endcase
    end

    // mode and animation updates
    always_comb begin
        n_mode     = r_mode;
        n_count    = r_count;
        n_level    = r_level;
        n_rising   = r_rising;
        n_wave     = r_wave;
        n_red_even = r_red_even;
        count_inc  = r_count + 8'd1;
        level_step = r_rising ? r_level + laps_pkg::PULSE_STEP
                              : r_level - laps_pkg::PULSE_STEP;

        if (i_cmd.do_command) begin
            case (i_command_byte)
                laps_pkg::CMD_OFF: n_mode = laps_pkg::MODE_OFF;
                laps_pkg::CMD_WAVE: begin
                    n_mode  = laps_pkg::MODE_WAVE;
                    n_count = 8'd0;
                end
                laps_pkg::CMD_PULSE: begin
                    n_mode  = laps_pkg::MODE_PULSE;
                    n_level = laps_pkg::PULSE_START;
                    n_count = 8'd0;
                end
                laps_pkg::CMD_REDYEL: begin
                    n_mode  = laps_pkg::MODE_REDYEL;
                    n_count = 8'd0;
                end
                default: n_mode = r_mode;
            endcase
        end

        if (i_cmd.do_rollover && (r_mode != laps_pkg::MODE_OFF)) begin
            n_count = count_inc;
            if (count_inc > r_timeout) n_mode = laps_pkg::MODE_OFF;
        end

        if (i_cmd.frame_end) begin
            case (r_mode)
                laps_pkg::MODE_WAVE: n_wave = laps_pkg::wave_next(r_wave);
                laps_pkg::MODE_PULSE: begin
                    n_level = level_step;
                    if (r_rising && (level_step > laps_pkg::PULSE_TOP)) n_rising = 1'b0;
                    if (!r_rising && (level_step < laps_pkg::PULSE_BOTTOM)) n_rising = 1'b1;
                end
                laps_pkg::MODE_REDYEL: n_red_even = !r_red_even;
                default: n_wave = r_wave;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= laps_pkg::MODE_OFF;
            r_count       <= 8'd0;
            r_level       <= laps_pkg::PULSE_RST;
            r_rising      <= 1'b1;
            r_wave        <= 4'd0;
            r_red_even    <= 1'b1;
            r_color_order <= laps_pkg::COLOR_ORDER_RST;
            r_timeout     <= laps_pkg::TIMEOUT_RST;
        end else begin
            r_mode     <= n_mode;
            r_count    <= n_count;
            r_level    <= n_level;
            r_rising   <= n_rising;
            r_wave     <= n_wave;
            r_red_even <= n_red_even;
            if (i_cfg_write && (i_cfg_index == laps_pkg::CFG_COLOR_ORDER))
                r_color_order <= i_cfg_data[0];
            if (i_cfg_write && (i_cfg_index == laps_pkg::CFG_TIMEOUT))
                r_timeout <= i_cfg_data;
        end
    end

    // led walk and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_start) begin
            r_led   <= '0;
            r_phase <= r_wave;
        end else if (i_cmd.load_led) begin
            r_led   <= r_led + laps_pkg::LED_W'(1);
            r_phase <= laps_pkg::wave_next(r_phase);
        end
        if (i_cmd.load_led) begin
            o_led_index   <= r_led;
            o_first_byte  <= r_color_order ? green : red;
            o_second_byte <= r_color_order ? red : green;
            o_third_byte  <= blue;
            o_last        <= o_status.last_led;
            o_hold_ms     <= hold;
        end
    end

endmodule

FILE: hw/rtl/led_alert_pattern_sequencer.sv
// top level of the led alert pattern sequencer
// depends on laps_pkg, laps_ctrl and laps_datapath
//
// usage
// - input channel (i_in_valid / o_in_stall) carries one word: an opcode and a
//   command byte. opcode command selects a display mode, rollover counts
//   toward auto shutoff, frame emits one output word per led
// - command and rollover words give no output
// - a frame word gives LED_COUNT output words, one per cycle while the
//   receiver keeps i_out_stall low; o_in_stall is high while the leds are
//   loaded, stepped by the single led walk counter in the datapath; the
//   first word is loaded into the output register once the controller is
//   in its emit state
// - output channel (o_out_valid / i_out_stall) comes from a register, so the
//   next input word is taken while the final led word still waits
// - a stalled output holds its word; the led walk pauses with it
// - config port (i_cfg_valid / o_cfg_ready) is always ready; index 0 is the
//   colour byte order, index 1 the timeout limit; write only while idle
// - synchronous reset: mode off, animation at its start, config at defaults,
//   no output pending
module led_alert_pattern_sequencer #(
    parameter int unsigned LED_COUNT = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [7:0]                     i_command_byte,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [laps_pkg::LED_W-1:0]     o_led_index,
    output logic [7:0]                     o_first_byte,
    output logic [7:0]                     o_second_byte,
    output logic [7:0]                     o_third_byte,
    output logic                           o_last,
    output logic [8:0]                     o_hold_ms,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [laps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    laps_pkg::t_dp_cmd    dp_cmd;
    laps_pkg::t_dp_status dp_status;

    // registers are plain flops, always able to take a write
    assign o_cfg_ready = 1'b1;

    laps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    laps_datapath #(
        .LED_COUNT (LED_COUNT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_command_byte (i_command_byte),
        .i_cfg_write    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_led_index    (o_led_index),
        .o_first_byte   (o_first_byte),
        .o_second_byte  (o_second_byte),
        .o_third_byte   (o_third_byte),
        .o_last         (o_last),
        .o_hold_ms      (o_hold_ms)
    );

endmodule

FILE: bench/tb_led_alert_pattern_sequencer.sv
// self-checking testbench for led_alert_pattern_sequencer: directed and random words,
// random idling on both channels, an in-bench mode predictor with an expected-word queue
// depends on laps_pkg and the led_alert_pattern_sequencer rtl
module tb_led_alert_pattern_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import laps_pkg::*;

    localparam int unsigned LEDS          = 16;
    localparam int unsigned GAP_PCT       = 28;    // chance of an idle cycle on each side
    localparam int unsigned HANG_LIMIT    = 4000;  // cycles with no handshake at all
    localparam int unsigned SETTLE_CYCLES = 4;     // idle time for a trailing command or rollover word
    localparam int unsigned WORD_TARGET   = 300;
    localparam int unsigned PHASE_WORDS   = 50;
    localparam logic [1:0]  OP_SPARE      = 2'd3;  // opcode with no meaning, must be ignored
    localparam logic [7:0]  FULL_RED      = 8'hFF;

    // one led word as it leaves the block
    typedef struct packed {
        logic [LED_W-1:0] led_index;
        logic [7:0]       first_byte;
        logic [7:0]       second_byte;
        logic [7:0]       third_byte;
        logic             last;
        logic [8:0]       hold_ms;
    } led_word_t;

    // tracks mode, shutoff count and animation; queues the led words of every frame
    class alert_scoreboard;
        t_mode       mode;
        logic [7:0]  rollovers;
        logic [7:0]  red_level;
        logic        red_rising;
        logic [3:0]  wave_phase;
        logic        red_on_even;
        logic        color_order;
        logic [7:0]  timeout_limit;
        logic [7:0]  blue_ramp [16];
        led_word_t   pending[$];
        int unsigned errors;
        int unsigned frames;
        int unsigned checked;

        function new();
            blue_ramp = '{8'h00, 8'h00, 8'h00, 8'h0F, 8'h1F, 8'h3F, 8'h7F, 8'hFF,
                          8'h7F, 8'h3F, 8'h1F, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00};
            mode          = MODE_OFF;
            rollovers     = '0;
            red_level     = PULSE_RST;
            red_rising    = 1'b1;
            wave_phase    = '0;
            red_on_even   = 1'b1;
            color_order   = COLOR_ORDER_RST;
            timeout_limit = TIMEOUT_RST;
            errors        = 0;
            frames        = 0;
            checked       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            case (idx)
                CFG_COLOR_ORDER: color_order = data[0];
                CFG_TIMEOUT:     timeout_limit = data;
                default: ;
            endcase
        endfunction

        // one accepted input word: update the state, queue any frame output
        function void note_word(logic [1:0] op, logic [7:0] code);
            led_word_t  w;
            logic [7:0] red;
            logic [7:0] green;
            logic [7:0] blue;
            logic [3:0] phase;
            logic [8:0] hold;
            case (op)
                OP_COMMAND: begin
                    case (code)
                        CMD_OFF: mode = MODE_OFF;
                        CMD_WAVE: begin
                            mode      = MODE_WAVE;
                            rollovers = '0;
                        end
                        CMD_PULSE: begin
                            mode      = MODE_PULSE;
                            red_level = PULSE_START;
                            rollovers = '0;
                        end
                        CMD_REDYEL: begin
                            mode      = MODE_REDYEL;
                            rollovers = '0;
                        end
                        default: ;
                    endcase
                end
                OP_ROLLOVER: begin
                    // shutoff timer is stopped while off
                    if (mode != MODE_OFF) begin
                        rollovers = rollovers + 8'd1;
                        if (rollovers > timeout_limit)
                            mode = MODE_OFF;
                    end
                end
                OP_FRAME: begin
                    frames++;
                    hold  = (mode == MODE_OFF) ? HOLD_OFF
                          : (mode == MODE_REDYEL) ? HOLD_REDYEL : HOLD_ANIM;
                    phase = wave_phase;
                    for (int i = 0; i < LEDS; i++) begin
                        red   = '0;
                        green = '0;
                        blue  = '0;
                        case (mode)
                            MODE_WAVE: begin
                                blue  = blue_ramp[phase];
                                phase = (phase >= WAVE_LAST) ? 4'd0 : phase + 4'd1;
                            end
                            MODE_PULSE: red = red_level;
                            MODE_REDYEL: begin
                                red   = FULL_RED;
                                green = (((i % 2) == 0) == red_on_even) ? 8'h00 : YELLOW_GREEN;
                            end
                            default: ;
                        endcase
                        w.led_index   = LED_W'(i);
                        w.first_byte  = color_order ? green : red;
                        w.second_byte = color_order ? red : green;
                        w.third_byte  = blue;
                        w.last        = (i == LEDS - 1);
                        w.hold_ms     = hold;
                        pending.push_back(w);
                    end
                    // animation moves on once the frame is out
                    case (mode)
                        MODE_WAVE:
                            wave_phase = (wave_phase >= WAVE_LAST) ? 4'd0 : wave_phase + 4'd1;
                        MODE_PULSE: begin
                            if (red_rising) begin
                                red_level = red_level + PULSE_STEP;
                                if (red_level > PULSE_TOP)
                                    red_rising = 1'b0;
                            end else begin
                                red_level = red_level - PULSE_STEP;
                                if (red_level < PULSE_BOTTOM)
                                    red_rising = 1'b1;
                            end
                        end
                        MODE_REDYEL: red_on_even = !red_on_even;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(led_word_t got);
            led_word_t want;
            if (pending.size() == 0) begin
                $error("led word for led %0d with no frame pending", got.led_index);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            compare_field("led_index", want.led_index, got.led_index);
            compare_field("first_byte", want.first_byte, got.first_byte);
            compare_field("second_byte", want.second_byte, got.second_byte);
            compare_field("third_byte", want.third_byte, got.third_byte);
            compare_field("last", want.last, got.last);
            compare_field("hold_ms", want.hold_ms, got.hold_ms);
        endfunction
    endclass

    // stimulus side, every input known from time zero
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic [1:0]           opcode       = OP_COMMAND;
    logic [7:0]           command_byte = 8'h00;
    logic                 out_stall    = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_COLOR_ORDER;
    logic [7:0]           cfg_data     = 8'h00;

    // block outputs
    logic                 in_stall;
    logic                 out_valid;
    logic [LED_W-1:0]     led_index;
    logic [7:0]           first_byte;
    logic [7:0]           second_byte;
    logic [7:0]           third_byte;
    logic                 last;
    logic [8:0]           hold_ms;
    logic                 cfg_ready;

    alert_scoreboard sb;
    bit              calm = 1'b0;       // high for a stretch with no idling on either side
    int unsigned     sent_words = 0;
    int unsigned     reg_writes = 0;
    int unsigned     quiet_cycles = 0;

    always #2 clk = ~clk;

    led_alert_pattern_sequencer #(
        .LED_COUNT(LEDS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_command_byte (command_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_led_index    (led_index),
        .o_first_byte   (first_byte),
        .o_second_byte  (second_byte),
        .o_third_byte   (third_byte),
        .o_last         (last),
        .o_hold_ms      (hold_ms),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    function automatic bit take_gap();
        return !calm && ($urandom_range(99) < GAP_PCT);
    endfunction

    // receiver stalls at random; changes only on the falling edge
    always @(negedge clk) begin
        out_stall <= take_gap();
    end

    // every accepted led word is checked against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(led_word_t'{led_index, first_byte, second_byte, third_byte,
                                      last, hold_ms});
    end

    // hang detector: no word moving on any channel for too long
    initial begin
        while (quiet_cycles < HANG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // offer one input word, with random idle cycles ahead of it
    // starts and ends at a falling edge; valid stays high for a following word
    task automatic put_word(input logic [1:0] op, input logic [7:0] code);
        while (take_gap()) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        command_byte <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(op, code);
        sent_words++;
        @(negedge clk);
    endtask

    // drain: no input offered, all frames out, then a few cycles for a trailing command
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one register write, only called while the block is idle
    task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        int unsigned phase;
        int unsigned phase_end;
        int unsigned burst_len;
        int unsigned pick;
        logic [7:0]  code;

        sb = new();

        // hold synchronous reset, then release it
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset configuration: green first, timeout 27
        put_word(OP_FRAME, 8'h00);       // frame while off: all dark, no hold
        put_word(OP_COMMAND, 8'h00);     // unknown button code
        put_word(OP_SPARE, 8'hFF);       // spare opcode
        put_word(OP_COMMAND, CMD_WAVE);
        put_word(OP_FRAME, 8'hFF);
        put_word(OP_FRAME, 8'h00);
        put_word(OP_COMMAND, CMD_PULSE); // pulse starts at full red, first step wraps
        put_word(OP_FRAME, 8'h00);
        put_word(OP_ROLLOVER, 8'h00);    // below the limit, mode stays
        put_word(OP_FRAME, 8'h00);
        put_word(OP_COMMAND, CMD_REDYEL);
        put_word(OP_FRAME, 8'h00);
        put_word(OP_FRAME, 8'h00);       // red and yellow swap parity
        put_word(OP_COMMAND, CMD_OFF);
        put_word(OP_ROLLOVER, 8'hFF);    // timer stopped while off
        put_word(OP_FRAME, 8'h00);

        // directed, red first and zero timeout: the first rollover ends the mode
        settle();
        load_reg(CFG_COLOR_ORDER, 8'h00);
        load_reg(CFG_TIMEOUT, 8'd0);
        put_word(OP_COMMAND, CMD_REDYEL);
        put_word(OP_FRAME, 8'h00);
        put_word(OP_ROLLOVER, 8'h00);
        put_word(OP_FRAME, 8'h00);
        put_word(OP_COMMAND, CMD_WAVE);
        put_word(OP_ROLLOVER, 8'h00);
        put_word(OP_FRAME, 8'h00);

        // random part: each phase has its own setting, words come in bursts of
        // a mode command followed by frames and rollovers, with some noise mixed in
        phase = 0;
        while (sent_words < WORD_TARGET) begin
            settle();
            case (phase)
                0: begin
                    load_reg(CFG_COLOR_ORDER, 8'h01);
                    load_reg(CFG_TIMEOUT, 8'd254);
                end
                1: begin
                    load_reg(CFG_COLOR_ORDER, 8'hFE);
                    load_reg(CFG_TIMEOUT, 8'd0);
                end
                default: begin
                    load_reg(CFG_COLOR_ORDER, 8'($urandom));
                    if ($urandom_range(3) == 0)
                        load_reg(CFG_TIMEOUT, 8'($urandom_range(254)));
                    else
                        load_reg(CFG_TIMEOUT, 8'($urandom_range(6)));
                end
            endcase
            calm = (phase == 2);
            phase_end = sent_words + PHASE_WORDS;
            while (sent_words < phase_end && sent_words < WORD_TARGET) begin
                // pick a mode, off only now and then
                if ($urandom_range(99) < 10)
                    code = CMD_OFF;
                else begin
                    case ($urandom_range(2))
                        0:       code = CMD_WAVE;
                        1:       code = CMD_PULSE;
                        default: code = CMD_REDYEL;
                    endcase
                end
                put_word(OP_COMMAND, code);
                burst_len = $urandom_range(2, 8);
                repeat (burst_len) begin
                    pick = $urandom_range(99);
                    if (pick < 4)
                        put_word(OP_SPARE, 8'($urandom));
                    else if (pick < 8)
                        put_word(OP_COMMAND, 8'($urandom));
                    else if (pick < 35)
                        put_word(OP_ROLLOVER, 8'($urandom));
                    else
                        put_word(OP_FRAME, 8'($urandom));
                end
            end
            phase++;
        end
        calm = 1'b0;

        // wait out the last frame, then a little longer for stray words
        settle();
        repeat (2 * LEDS) @(negedge clk);

        $display("run covered %0d input words, %0d frames and %0d led words over %0d phases",
                 sent_words, sb.frames, sb.checked, phase);
        $display("%0d register writes, %0d mismatches", reg_writes, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/laps_pkg.sv
hw/rtl/laps_ctrl.sv
hw/rtl/laps_datapath.sv
hw/rtl/led_alert_pattern_sequencer.sv
bench/tb_led_alert_pattern_sequencer.sv
